>>> design/stateful_packet_filter_macros.svh
// assertion macros for the stateful packet filter
`ifndef STATEFUL_PACKET_FILTER_MACROS_SVH
`define STATEFUL_PACKET_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define SPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// types, constants and helpers shared by the packet filter modules
// ----------------------------------------------------------------------------
package spf_pkg;
    localparam int MAX_RULES   = 16;
    localparam int BUCKET_BITS = 10;
    localparam int FLOW_WAYS   = 4;
    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int RULE_BITS   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int COUNT_BITS  = $clog2(MAX_RULES + 1);
    localparam int WAY_BITS    = (FLOW_WAYS > 1) ? $clog2(FLOW_WAYS) : 1;

    localparam logic [1:0] FUNC_CLASSIFY = 2'd0;
    localparam logic [1:0] FUNC_INSERT   = 2'd1;
    localparam logic [1:0] FUNC_DELETE   = 2'd2;

    localparam logic [1:0] BY_FLOW    = 2'd0;
    localparam logic [1:0] BY_RULE    = 2'd1;
    localparam logic [1:0] BY_DEFAULT = 2'd2;
    localparam logic [1:0] BY_RULEOP  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [8:0] PROTO_ICMP = 9'h001;
    localparam logic [8:0] PROTO_TCP  = 9'h006;
    localparam logic [8:0] PROTO_UDP  = 9'h011;
    localparam logic [8:0] PROTO_ANY  = 9'd256;
    localparam int         HASH_SHIFT = 4;

    typedef struct packed {
        logic [31:0] sip;
        logic [31:0] smask;
        logic [31:0] dip;
        logic [31:0] dmask;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [8:0]  proto;
        logic        accept;
        logic        log;
    } rule_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [8:0]  proto;
    } flow_t;

    localparam int FLOW_W   = $bits(flow_t);
    localparam int BUCKET_W = FLOW_W * FLOW_WAYS;

    typedef struct packed {
        logic                   hit;
        logic [RULE_BITS-1:0]   index;
        logic                   accept;
        logic                   log;
    } match_t;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0)
            m = 32'h0;
        else if (len >= 6'd32)
            m = 32'hffffffff;
        else
            m = 32'hffffffff << (6'd32 - len);
        return m;
    endfunction
endpackage

>>> design/spf_ram.sv
// ----------------------------------------------------------------------------
// spf_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> design/spf_rule_list.sv
// ----------------------------------------------------------------------------
// spf_rule_list
// ordered rule list in registers with parallel first-match compare
// ----------------------------------------------------------------------------
module spf_rule_list (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ins,
    input  logic                          del,
    input  logic [spf_pkg::COUNT_BITS-1:0] at,
    input  spf_pkg::rule_t                new_rule,
    input  logic [31:0]                   sip,
    input  logic [31:0]                   dip,
    input  logic [15:0]                   sp,
    input  logic [15:0]                   dp,
    input  logic [8:0]                    proto,
    output logic [spf_pkg::COUNT_BITS-1:0] count,
    output spf_pkg::match_t               match
);
    import spf_pkg::*;

    rule_t                 rules_reg [MAX_RULES];
    logic [COUNT_BITS-1:0] count_reg;
    logic [MAX_RULES-1:0]  hit;
    match_t                match_next;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RULES; k++)
        begin
            if (ins)
            begin
                if (k == int'(at))
                    rules_reg[k] <= new_rule;
                else if (k > int'(at) && k > 0)
                    rules_reg[k] <= rules_reg[k-1];
            end
            else if (del && k >= int'(at) && k < MAX_RULES - 1)
                rules_reg[k] <= rules_reg[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ins)
            count_reg <= count_reg + 1'b1;
        else if (del)
            count_reg <= count_reg - 1'b1;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_RULES; k++)
        begin
            hit[k] = (k < int'(count_reg))
                && ((rules_reg[k].sip & rules_reg[k].smask) == (sip & rules_reg[k].smask))
                && ((rules_reg[k].dip & rules_reg[k].dmask) == (dip & rules_reg[k].dmask))
                && (rules_reg[k].sp == 16'd0 || rules_reg[k].sp == sp)
                && (rules_reg[k].dp == 16'd0 || rules_reg[k].dp == dp)
                && (rules_reg[k].proto == PROTO_ANY || rules_reg[k].proto == proto);
        end
    end

    always_comb
    begin
        match_next = '0;
        for (int k = MAX_RULES - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                match_next.hit    = 1'b1;
                match_next.index  = RULE_BITS'(k);
                match_next.accept = rules_reg[k].accept;
                match_next.log    = rules_reg[k].log;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        match <= match_next;
    end

    assign count = count_reg;
endmodule

>>> design/stateful_packet_filter.sv
// ----------------------------------------------------------------------------
// stateful_packet_filter
// five-tuple classifier with flow memory and ordered rule list
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     func, addresses, ports, protocol, rule fields
//  result    done strobe      verdict_accept, decided_by, rule_index, ...
//  config    cfg_we           cfg_data -> default_accept
// a packet goes through latch, bucket read, compare and write back, result
// rule operations go through latch, list update, result; busy is high while a word is in work
// after reset a clearing pass over all NUM_BUCKETS (1024) buckets holds busy high
// the result is shown for one cycle with done and cannot be stalled
module stateful_packet_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic [1:0]  func,
    input  logic [31:0] src_ip,
    input  logic [31:0] dst_ip,
    input  logic [15:0] sport,
    input  logic [15:0] dport,
    input  logic [8:0]  protocol,
    input  logic [5:0]  src_prefix_len,
    input  logic [5:0]  dst_prefix_len,
    input  logic        rule_accept,
    input  logic        rule_log,
    input  logic [4:0]  position,
    output logic        done,
    output logic        verdict_accept,
    output logic [1:0]  decided_by,
    output logic [3:0]  rule_index,
    output logic        log_request,
    output logic [1:0]  status
);
    import spf_pkg::*;
    `include "stateful_packet_filter_macros.svh"

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_RULE  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [BUCKET_BITS-1:0] clr_reg;
    logic                   def_reg;
    logic [1:0]             func_reg;
    logic [31:0]            sip_reg, dip_reg;
    logic [15:0]            sp_reg, dp_reg;
    logic [8:0]             proto_reg;
    logic [5:0]             spl_reg, dpl_reg;
    logic                   racc_reg, rlog_reg;
    logic [4:0]             pos_reg;
    logic                   done_reg;
    logic                   vacc_reg, log_reg;
    logic [1:0]             by_reg, st_reg;
    logic [3:0]             idx_reg;

    logic                   is_l4;
    logic [15:0]            sp_in, dp_in;
    logic [31:0]            hash;
    logic [BUCKET_BITS-1:0] bucket_reg;

    logic                   fl_we;
    logic [BUCKET_BITS-1:0] fl_addr;
    logic [BUCKET_W-1:0]    fl_wdata, fl_rdata;
    logic                   vi_we;
    logic [WAY_BITS-1:0]    vi_wdata, vi_rdata;
    logic [WAY_BITS-1:0]    vi_fit;

    logic [COUNT_BITS-1:0]  count;
    match_t                 match;
    rule_t                  new_rule;
    logic                   r_ins, r_del;
    logic [COUNT_BITS-1:0]  r_at;
    logic [1:0]             r_st;

    flow_t                  ways [FLOW_WAYS];
    logic                   flow_hit;
    logic                   have_free;
    logic [WAY_BITS-1:0]    free_way, slot;
    flow_t                  new_flow;
    logic                   install;

    assign busy  = (state_reg != S_IDLE);
    assign is_l4 = (protocol == PROTO_TCP) || (protocol == PROTO_UDP);
    assign sp_in = is_l4 ? sport : 16'd0;
    assign dp_in = is_l4 ? dport : 16'd0;
    assign hash  = ((src_ip + dst_ip) << HASH_SHIFT) + 32'(protocol)
                 + 32'(sp_in) + 32'(dp_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            def_reg   <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (cfg_we)
                def_reg <= cfg_data;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_CMP || state_reg == S_RULE)
                done_reg <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == BUCKET_BITS'(NUM_BUCKETS - 1)) state_next = S_IDLE;
            S_IDLE:
                if (start)
                    state_next = (func == FUNC_CLASSIFY) ? S_READ : S_RULE;
            S_READ:  state_next = S_CMP;
            S_CMP:   state_next = S_IDLE;
            S_RULE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            func_reg   <= func;
            sip_reg    <= src_ip;
            dip_reg    <= dst_ip;
            proto_reg  <= protocol;
            spl_reg    <= src_prefix_len;
            dpl_reg    <= dst_prefix_len;
            racc_reg   <= rule_accept;
            rlog_reg   <= rule_log;
            pos_reg    <= position;
            bucket_reg <= hash[BUCKET_BITS-1:0];
            if (func == FUNC_CLASSIFY)
                sp_reg <= sp_in;
            else
                sp_reg <= sport;
            if (func == FUNC_CLASSIFY)
                dp_reg <= dp_in;
            else
                dp_reg <= dport;
        end
        if (state_reg == S_CMP)
        begin
            st_reg <= ST_OK;
            if (flow_hit)
            begin
                vacc_reg <= 1'b1; by_reg <= BY_FLOW; idx_reg <= '0; log_reg <= 1'b1;
            end
            else if (match.hit)
            begin
                vacc_reg <= match.accept; by_reg <= BY_RULE;
                idx_reg  <= 4'(match.index); log_reg <= match.log;
            end
            else
            begin
                vacc_reg <= def_reg; by_reg <= BY_DEFAULT; idx_reg <= '0; log_reg <= 1'b0;
            end
        end
        if (state_reg == S_RULE)
        begin
            vacc_reg <= 1'b0; by_reg <= BY_RULEOP; idx_reg <= '0; log_reg <= 1'b0;
            st_reg   <= r_st;
        end
    end

    // flow compare on the bucket read back
    always_comb
    begin
        flow_hit  = 1'b0;
        have_free = 1'b0;
        free_way  = '0;
        for (int w = 0; w < FLOW_WAYS; w++)
        begin
            ways[w] = fl_rdata[w*FLOW_W +: FLOW_W];
            if (ways[w].valid && ways[w].sip == sip_reg && ways[w].dip == dip_reg
                && (ways[w].sp == 16'd0 || ways[w].sp == sp_reg)
                && (ways[w].dp == 16'd0 || ways[w].dp == dp_reg)
                && ways[w].proto == proto_reg)
                flow_hit = 1'b1;
        end
        for (int w = FLOW_WAYS - 1; w >= 0; w--)
        begin
            if (!ways[w].valid)
            begin
                have_free = 1'b1;
                free_way  = WAY_BITS'(w);
            end
        end
    end

    assign vi_fit = (int'(vi_rdata) >= FLOW_WAYS - 1) ? '0 : vi_rdata + 1'b1;
    assign slot   = have_free ? free_way : ((int'(vi_rdata) >= FLOW_WAYS) ? '0 : vi_rdata);

    always_comb
    begin
        new_flow.valid = 1'b1;
        new_flow.sip   = sip_reg;
        new_flow.dip   = dip_reg;
        new_flow.sp    = sp_reg;
        new_flow.dp    = dp_reg;
        new_flow.proto = proto_reg;
        fl_wdata = fl_rdata;
        if (state_reg == S_CLEAR)
            fl_wdata = '0;
        else
            fl_wdata[int'(slot)*FLOW_W +: FLOW_W] = new_flow;
    end

    assign install  = (state_reg == S_CMP) && !flow_hit && match.hit && match.accept;
    assign fl_we    = (state_reg == S_CLEAR) || install;
    assign fl_addr  = (state_reg == S_CLEAR) ? clr_reg
                    : (state_reg == S_IDLE) ? hash[BUCKET_BITS-1:0] : bucket_reg;
    assign vi_we    = (state_reg == S_CLEAR) || (install && !have_free);
    assign vi_wdata = (state_reg == S_CLEAR) ? '0 : vi_fit;

    spf_ram #(.WIDTH(BUCKET_W), .DEPTH(NUM_BUCKETS)) u_flow_ram (
        .clk(clk), .we(fl_we), .addr(fl_addr), .wdata(fl_wdata), .rdata(fl_rdata)
    );

    spf_ram #(.WIDTH(WAY_BITS), .DEPTH(NUM_BUCKETS)) u_victim_ram (
        .clk(clk), .we(vi_we), .addr(fl_addr), .wdata(vi_wdata), .rdata(vi_rdata)
    );

    // rule operation decode
    always_comb
    begin
        new_rule.sip    = sip_reg;
        new_rule.dip    = dip_reg;
        new_rule.smask  = prefix_mask(spl_reg);
        new_rule.dmask  = prefix_mask(dpl_reg);
        new_rule.proto  = proto_reg;
        new_rule.accept = racc_reg;
        new_rule.log    = rlog_reg;
        new_rule.sp     = (proto_reg == PROTO_ICMP) ? 16'd0 : sp_reg;
        new_rule.dp     = (proto_reg == PROTO_ICMP) ? 16'd0 : dp_reg;
        r_ins = 1'b0;
        r_del = 1'b0;
        r_at  = '0;
        r_st  = ST_OK;
        if (func_reg == FUNC_INSERT)
        begin
            if (6'(pos_reg) > 6'(count))
                r_st = ST_RANGE;
            else if (int'(count) >= MAX_RULES)
                r_st = ST_FULL;
            else
            begin
                r_ins = (state_reg == S_RULE);
                r_at  = (pos_reg == 5'd0) ? count : COUNT_BITS'(pos_reg - 5'd1);
            end
        end
        else if (func_reg == FUNC_DELETE)
        begin
            if (pos_reg == 5'd0 || 6'(pos_reg) > 6'(count))
                r_st = ST_RANGE;
            else
            begin
                r_del = (state_reg == S_RULE);
                r_at  = COUNT_BITS'(pos_reg - 5'd1);
            end
        end
    end

    spf_rule_list u_rules (
        .clk(clk), .rst_n(rst_n), .ins(r_ins), .del(r_del), .at(r_at),
        .new_rule(new_rule), .sip(sip_reg), .dip(dip_reg), .sp(sp_reg),
        .dp(dp_reg), .proto(proto_reg), .count(count), .match(match)
    );

    assign done           = done_reg;
    assign verdict_accept = vacc_reg;
    assign decided_by     = by_reg;
    assign rule_index     = idx_reg;
    assign log_request    = log_reg;
    assign status         = st_reg;

    `SPF_ASSERT_IMP(a_no_start_clear, clk, rst_n, state_reg == S_CLEAR, busy)
    `SPF_ASSERT_NXT(a_done_after_op, clk, rst_n, state_reg == S_CMP || state_reg == S_RULE, done)
    `SPF_ASSERT_IMP(a_install_needs_rule, clk, rst_n, install, match.hit && !flow_hit)
    `SPF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, int'(count) <= MAX_RULES)
endmodule
